// File: hdl/sm4_block_cipher_unit_macros.svh
// Assertion macros shared by the SM4 cipher unit.
`ifndef SM4_BLOCK_CIPHER_UNIT_MACROS_SVH
`define SM4_BLOCK_CIPHER_UNIT_MACROS_SVH
// Clocked implication checked outside reset.
`define SM4_ASSERT_IMP(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define SM4_ASSERT_NXT(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error("assertion failed");
`endif

// File: hdl/sm4_pkg.sv
// Package for the SM4 cipher unit: S-box, constants and round functions.
`timescale 1ns / 1ps
package sm4_pkg;
    localparam int NumRounds = 32;
    localparam int RoundIdxW = 5;
    localparam int KeyRegIdxW = 2;

    typedef enum logic [KeyRegIdxW-1:0] {
        KEY_WORD_0 = 2'd0,
        KEY_WORD_1 = 2'd1,
        KEY_WORD_2 = 2'd2,
        KEY_WORD_3 = 2'd3
    } key_reg_idx_t;

    localparam logic [31:0] FK0 = 32'ha3b1bac6;
    localparam logic [31:0] FK1 = 32'h56aa3350;
    localparam logic [31:0] FK2 = 32'h677d9197;
    localparam logic [31:0] FK3 = 32'hb27022dc;

    // data moving down the cipher chain
    typedef struct packed {
        logic        valid;
        logic        decrypt;
        logic [31:0] x0;
        logic [31:0] x1;
        logic [31:0] x2;
        logic [31:0] x3;
    } blk_t;

    // key expansion status
    typedef struct packed {
        logic busy;
        logic done;
    } kx_stat_t;

    localparam logic [7:0] SBOX [256] = '{
        8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
        8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
        8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
        8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
        8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
        8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
        8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
        8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
        8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
        8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
        8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
        8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
        8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
        8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
        8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
        8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
    };

    function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
        rotl = (v << n) | (v >> (32 - n));
    endfunction

    function automatic logic [31:0] subst_word(input logic [31:0] v);
        subst_word = {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
    endfunction

    function automatic logic [31:0] round_mix(input logic [31:0] v);
        logic [31:0] b;
        b = subst_word(v);
        round_mix = b ^ rotl(b, 2) ^ rotl(b, 10) ^ rotl(b, 18) ^ rotl(b, 24);
    endfunction

    function automatic logic [31:0] key_mix(input logic [31:0] v);
        logic [31:0] b;
        b = subst_word(v);
        key_mix = b ^ rotl(b, 13) ^ rotl(b, 23);
    endfunction

    // CK byte j of round i is (4i + j) * 7 mod 256
    function automatic logic [31:0] ck_word(input logic [RoundIdxW-1:0] i);
        logic [7:0] base;
        base = {1'b0, i, 2'b00} * 8'd7;
        ck_word = {base, base + 8'd7, base + 8'd14, base + 8'd21};
    endfunction
endpackage

// File: hdl/sm4_block_cipher_unit.sv
// Top level of the SM4 cipher unit: key registers, key expansion and 32-cell round chain.
//
// s_ channel takes one 128-bit block per item with a decrypt flag in s_tuser;
// m_ channel returns the 128-bit result, words reversed as SM4 defines.
// Key words 0..3 are written on cfg_we/cfg_addr/cfg_wdata; any write starts
// a key expansion in the cycle after it (one round key per cycle), so s_tready
// is held low from the start of the expansion until it ends.
// Write keys only while the block is idle.
// An accepted block reaches m_tvalid through the registers of every round cell in order.
// Throughput is one item per cycle while no key expansion runs and the chain
// advances: each cell holds one block and hands it on each cycle the chain advances.
// The chain advances whenever the last cell is empty or its item is taken;
// a stalled receiver freezes the whole chain and drops s_tready.
// Reset clears key registers and all valid flags; the round keys are
// undefined until the first key write completes its expansion.
`timescale 1ns / 1ps
module sm4_block_cipher_unit
    import sm4_pkg::*;
#(
    parameter int NUM_ROUNDS = NumRounds
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // in_word_0, in_word_1, in_word_2, in_word_3
    input  logic         s_tuser,   // decrypt
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // out_word_0, out_word_1, out_word_2, out_word_3
    input  logic         cfg_we,
    input  logic [1:0]   cfg_addr,
    input  logic [31:0]  cfg_wdata
);
    `include "sm4_block_cipher_unit_macros.svh"

    logic [3:0][31:0] key_reg;
    kx_stat_t         kx_stat;
    logic [NUM_ROUNDS-1:0][31:0] rk;
    blk_t             chain [NUM_ROUNDS+1];
    logic             adv;
    logic             start;

    // key registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg <= '0;
        end else if (cfg_we) begin
            unique case (key_reg_idx_t'(cfg_addr))
                KEY_WORD_0: key_reg[3] <= cfg_wdata;
                KEY_WORD_1: key_reg[2] <= cfg_wdata;
                KEY_WORD_2: key_reg[1] <= cfg_wdata;
                KEY_WORD_3: key_reg[0] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // expansion starts the cycle after a write, from the updated key
    always_ff @(posedge aclk) begin
        if (!aresetn) start <= 1'b0;
        else          start <= cfg_we;
    end

    sm4_keyx #(.NUM_ROUNDS(NUM_ROUNDS)) u_keyx (
        .aclk(aclk), .aresetn(aresetn), .start(start),
        .key({key_reg[3], key_reg[2], key_reg[1], key_reg[0]}),
        .stat(kx_stat), .rk(rk)
    );

    assign adv      = !chain[NUM_ROUNDS].valid || m_tready;
    assign s_tready = adv && !kx_stat.busy && !start;

    assign chain[0].valid   = s_tvalid && s_tready;
    assign chain[0].decrypt = s_tuser;
    assign chain[0].x0      = s_tdata[31:0];
    assign chain[0].x1      = s_tdata[63:32];
    assign chain[0].x2      = s_tdata[95:64];
    assign chain[0].x3      = s_tdata[127:96];

    // round chain
    for (genvar i = 0; i < NUM_ROUNDS; i++) begin : g_cell
        sm4_cell u_cell (
            .aclk(aclk), .aresetn(aresetn), .en(adv),
            .rk_enc(rk[i]), .rk_dec(rk[NUM_ROUNDS-1-i]),
            .blk_in(chain[i]), .blk_out(chain[i+1])
        );
    end

    assign m_tvalid = chain[NUM_ROUNDS].valid;
    assign m_tdata  = {chain[NUM_ROUNDS].x0, chain[NUM_ROUNDS].x1,
                       chain[NUM_ROUNDS].x2, chain[NUM_ROUNDS].x3};

    `SM4_ASSERT_IMP(a_no_in_during_kx, aclk, aresetn, kx_stat.busy, !s_tready)
    `SM4_ASSERT_NXT(a_stall_holds, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `SM4_ASSERT_NXT(a_kx_after_write, aclk, aresetn, cfg_we, start)
    `SM4_ASSERT_NXT(a_kx_ends, aclk, aresetn, kx_stat.done && !start, !kx_stat.busy)
endmodule

// File: hdl/sm4_keyx.sv
// Key expansion sequencer: one round key per cycle into the round-key register file.
`timescale 1ns / 1ps
module sm4_keyx
    import sm4_pkg::*;
#(
    parameter int NUM_ROUNDS = NumRounds
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [127:0]          key,
    output kx_stat_t              stat,
    output logic [NUM_ROUNDS-1:0][31:0] rk
);
    localparam int IW = $clog2(NUM_ROUNDS);

    logic [IW-1:0] idx_reg, idx_next;
    logic          busy_reg, busy_next;
    logic [31:0]   k0_reg, k1_reg, k2_reg, k3_reg;
    logic [31:0]   nk;
    logic [NUM_ROUNDS-1:0][31:0] rk_reg;

    assign nk = k0_reg ^ key_mix(k1_reg ^ k2_reg ^ k3_reg ^ ck_word(RoundIdxW'(idx_reg)));

    // sequencer control
    always_comb begin
        idx_next  = idx_reg;
        busy_next = busy_reg;
        if (start) begin
            idx_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            idx_next = idx_reg + 1'b1;
            if (idx_reg == IW'(NUM_ROUNDS - 1)) busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg  <= '0;
            busy_reg <= 1'b0;
        end else begin
            idx_reg  <= idx_next;
            busy_reg <= busy_next;
        end
    end

    // key word shift and round-key writes
    always_ff @(posedge aclk) begin
        if (start) begin
            k0_reg <= key[127:96] ^ FK0;
            k1_reg <= key[95:64] ^ FK1;
            k2_reg <= key[63:32] ^ FK2;
            k3_reg <= key[31:0] ^ FK3;
        end else if (busy_reg) begin
            k0_reg <= k1_reg;
            k1_reg <= k2_reg;
            k2_reg <= k3_reg;
            k3_reg <= nk;
            rk_reg[idx_reg] <= nk;
        end
    end

    assign rk        = rk_reg;
    assign stat.busy = busy_reg;
    assign stat.done = busy_reg && (idx_reg == IW'(NUM_ROUNDS - 1));
endmodule

// File: hdl/sm4_cell.sv
// One round cell of the cipher chain.
`timescale 1ns / 1ps
module sm4_cell
    import sm4_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  logic [31:0] rk_enc,
    input  logic [31:0] rk_dec,
    input  blk_t        blk_in,
    output blk_t        blk_out
);
    blk_t        blk_reg;
    logic [31:0] rk;
    logic [31:0] nx;

    assign rk = blk_in.decrypt ? rk_dec : rk_enc;
    assign nx = blk_in.x0 ^ round_mix(blk_in.x1 ^ blk_in.x2 ^ blk_in.x3 ^ rk);

    // round register, held while the chain is stalled
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blk_reg.valid <= 1'b0;
        end else if (en) begin
            blk_reg.valid <= blk_in.valid;
        end
        if (en) begin
            blk_reg.decrypt <= blk_in.decrypt;
            blk_reg.x0      <= blk_in.x1;
            blk_reg.x1      <= blk_in.x2;
            blk_reg.x2      <= blk_in.x3;
            blk_reg.x3      <= nx;
        end
    end

    assign blk_out = blk_reg;
endmodule

// File: bench/tb_sm4_block_cipher_unit.sv
// Self-checking testbench for the SM4 block cipher unit.
`timescale 1ns / 1ps
module tb_sm4_block_cipher_unit;
    import sm4_pkg::*;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata = '0;   // in_word_0, in_word_1, in_word_2, in_word_3
    logic         s_tuser = 1'b0; // decrypt
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [127:0] m_tdata;        // out_word_0, out_word_1, out_word_2, out_word_3
    logic         cfg_we = 1'b0;
    logic [1:0]   cfg_addr = '0;
    logic [31:0]  cfg_wdata = '0;

    int send_idle_pct;
    int recv_idle_pct;
    int mismatches;
    int stuck_cycles;

    always #1 aclk = ~aclk;

    sm4_block_cipher_unit dut (.*);

    task automatic report_error(string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // Cipher predictor and queue of expected result blocks
    class sm4_scoreboard;
        bit [31:0]  key_words[4];
        bit [31:0]  sched_rk[32];
        bit [127:0] pending_blocks[$];

        function automatic bit [31:0] rot(bit [31:0] v, int n);
            return (v << n) | (v >> (32 - n));
        endfunction

        function automatic bit [31:0] sbox_word(bit [31:0] v);
            return {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
        endfunction

        // Key register write followed by a fresh round key schedule
        function void set_key(key_reg_idx_t idx, bit [31:0] value);
            bit [31:0] k[4];
            bit [31:0] t;
            bit [31:0] ck;
            bit [7:0]  b;
            key_words[idx] = value;
            k[0] = key_words[0] ^ FK0;
            k[1] = key_words[1] ^ FK1;
            k[2] = key_words[2] ^ FK2;
            k[3] = key_words[3] ^ FK3;
            for (int i = 0; i < 32; i++) begin
                for (int j = 0; j < 4; j++) begin
                    b = 8'((4 * i + j) * 7);
                    ck = (ck << 8) | b;
                end
                t = sbox_word(k[1] ^ k[2] ^ k[3] ^ ck);
                t = k[0] ^ t ^ rot(t, 13) ^ rot(t, 23);
                sched_rk[i] = t;
                k[0] = k[1]; k[1] = k[2]; k[2] = k[3]; k[3] = t;
            end
        endfunction

        function void note_block(bit [127:0] data, bit decrypt);
            bit [31:0] x[4];
            bit [31:0] t;
            for (int i = 0; i < 4; i++) x[i] = data[32*i +: 32];
            for (int i = 0; i < 32; i++) begin
                t = sbox_word(x[1] ^ x[2] ^ x[3] ^ sched_rk[decrypt ? 31 - i : i]);
                t = x[0] ^ t ^ rot(t, 2) ^ rot(t, 10) ^ rot(t, 18) ^ rot(t, 24);
                x[0] = x[1]; x[1] = x[2]; x[2] = x[3]; x[3] = t;
            end
            pending_blocks.push_back({x[0], x[1], x[2], x[3]});
        endfunction

        task check_block(bit [127:0] got);
            bit [127:0] want;
            if (pending_blocks.size() == 0) begin
                report_error($sformatf("unexpected result %h", got));
                return;
            end
            want = pending_blocks.pop_front();
            for (int w = 0; w < 4; w++)
                if (got[32*w +: 32] !== want[32*w +: 32])
                    report_error($sformatf("out_word_%0d got %h want %h",
                                           w, got[32*w +: 32], want[32*w +: 32]));
        endtask
    endclass

    sm4_scoreboard sb = new();

    task automatic write_key(key_reg_idx_t idx, bit [31:0] value);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we <= 1'b0;
        sb.set_key(idx, value);
    endtask

    task automatic load_key(bit [127:0] key);
        write_key(KEY_WORD_0, key[127:96]);
        write_key(KEY_WORD_1, key[95:64]);
        write_key(KEY_WORD_2, key[63:32]);
        write_key(KEY_WORD_3, key[31:0]);
    endtask

    // Present one item and hold it until accepted
    task automatic send_block(bit [127:0] data, bit decrypt);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= data;
        s_tuser <= decrypt;
        do @(posedge aclk); while (!s_tready);
        sb.note_block(data, decrypt);
        @(negedge aclk);
    endtask

    // Called at a falling edge: stop sending and wait for the pipeline to empty
    task automatic drain;
        s_tvalid <= 1'b0;
        while (sb.pending_blocks.size() != 0) @(negedge aclk);
        repeat (40) @(negedge aclk);
    endtask

    function automatic bit [127:0] rand_block();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    // Receiver stalls and result checking
    always @(negedge aclk) m_tready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_block(m_tdata);
    end

    // Watchdog on cycles with no accepted item
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles > 20000) begin
            $display("tb_sm4_block_cipher_unit NOT OK");
            $finish;
        end
    end

    initial begin
        bit [127:0] blk;
        mismatches = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: standard test key, extremes, both directions
        load_key(128'h0123456789abcdeffedcba9876543210);
        send_block(128'h76543210fedcba9889abcdef01234567, 1'b0);
        send_block(128'h536e4246_86b3e94f_d206965e_681edf34, 1'b1);
        send_block('0, 1'b0);
        send_block('0, 1'b1);
        send_block('1, 1'b0);
        send_block('1, 1'b1);
        send_block({4{32'haaaaaaaa}}, 1'b0);
        send_block({4{32'h55555555}}, 1'b1);
        drain();
        load_key('0);
        send_block('0, 1'b0);
        send_block('1, 1'b1);
        drain();
        load_key('1);
        send_block('0, 1'b1);
        send_block('1, 1'b0);
        send_block({4{32'h80000001}}, 1'b0);
        drain();

        // Random phases with changing keys and idle patterns
        for (int phase = 0; phase < 6; phase++) begin
            case (phase % 3)
                0: begin send_idle_pct = 29; recv_idle_pct = 79; end
                1: begin send_idle_pct = 79; recv_idle_pct = 29; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            load_key(rand_block());
            if (phase == 5) write_key(key_reg_idx_t'($urandom_range(3)), $urandom);
            for (int n = 0; n < 190; n++) begin
                blk = rand_block();
                send_block(blk, $urandom_range(1));
            end
            drain();
        end

        if (mismatches == 0)
            $display("tb_sm4_block_cipher_unit OK");
        else
            $display("tb_sm4_block_cipher_unit NOT OK");
        $finish;
    end
endmodule
